// File: design/text_console_cursor_writer_core_defines.svh
// ----------------------------------------------------------------------------
// Console cursor writer: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_CORE_DEFINES_SVH

// Check an implication or sequence property on every rising clock edge.
`define CCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge.
`define CCW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: design/ccw_pkg.sv
// ----------------------------------------------------------------------------
// Console cursor writer package
// Grid geometry, field widths, codes and shared types.
// ----------------------------------------------------------------------------
package ccw_pkg;

  // Grid geometry
  localparam int COLUMNS     = 160;
  localparam int ROWS        = 80;
  localparam int CELL_WIDTH  = 8;
  localparam int CELL_HEIGHT = 12;

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Field widths
  localparam int CMD_W     = 3;
  localparam int CHAR_W    = 8;
  localparam int VALUE_W   = 31;
  localparam int OP_W      = 2;
  localparam int PIXEL_X_W = 11;
  localparam int PIXEL_Y_W = 10;
  localparam int GLYPH_W   = 8;
  localparam int COLOR_W   = 24;

  // Digit buffer: ten digits cover any 31-bit value in decimal
  localparam int DIGITS      = 10;
  localparam int DIGIT_W     = 4;
  localparam int DIGIT_BITS  = DIGITS * DIGIT_W;
  localparam int DIG_CNT_W   = $clog2(DIGITS + 1);
  localparam int CONV_CNT_W  = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [GLYPH_W-1:0] ASCII_ZERO   = 8'h30;
  localparam logic [GLYPH_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] COLOR_BLACK  = 24'h000000;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHAR      = 3'd0,
    CMD_BACKSPACE = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_DEC       = 3'd3,
    CMD_HEX       = 3'd4
  } cmd_e;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW  = 2'd0,
    OP_ERASE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Cursor moves requested by the sequencer
  typedef struct packed {
    logic newline;
    logic backspace;
    logic advance;
    logic home;
  } curs_cmd_t;

  // Digit unit control and status
  typedef struct packed {
    logic                     start;
    logic                     hex;
    logic                     next;
  } dig_ctrl_t;

  typedef struct packed {
    logic                     ready;
    logic                     last;
    logic [DIGIT_W-1:0]       digit;
  } dig_sts_t;

  // ASCII for one digit, uppercase beyond nine
  function automatic logic [GLYPH_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [GLYPH_W-1:0] g;
    if (d < 4'd10) begin
      g = ASCII_ZERO + GLYPH_W'(d);
    end else begin
      g = ASCII_UPPER_A + GLYPH_W'(d - 4'd10);
    end
    return g;
  endfunction

endpackage

// File: design/text_console_cursor_writer_core.sv
// ----------------------------------------------------------------------------
// Text console cursor writer core
// Turns console commands into framebuffer draw, erase and clear beats.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                   Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready cmd, char_code, value
//   m_axis    out        m_axis_tvalid/m_axis_tready op, pixel_x, pixel_y, glyph,
//                                                    color; last on tlast
//   cfg       in         cfg_we_i (no wait)          draw_color
//
// A command beat is taken only while idle. Newline and unused codes need no further state;
// a character, erase or clear passes through a state of its own that loads the output register.
// Decimal values go through bit-serial BCD conversion, a phase that drops leading zeros
// and a phase that shifts out one digit per output beat. Hex skips the conversion.
// Reset clears cursor and sequencer and sets the colour to white, with no clearing
// pass; a stalled m_axis holds the sequencer and input while a beat waits.
//
`include "text_console_cursor_writer_core_defines.svh"

module text_console_cursor_writer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg: draw colour, red in the top byte
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  // s_axis tdata: cmd [2:0], char_code [10:3], value [41:11], zero pad
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // m_axis tdata: op [1:0], pixel_x [12:2], pixel_y [22:13], glyph [30:23],
  //               color [54:31], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import ccw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GLYPH,
    S_ERASE,
    S_CLEAR,
    S_DIGITS
  } state_e;

  state_e state_q, state_d;

  // Unpack the incoming beat
  logic [CMD_W-1:0]   in_cmd;
  logic [CHAR_W-1:0]  in_char;
  logic [VALUE_W-1:0] in_value;
  logic               in_accept;

  assign in_cmd   = s_axis_tdata[CMD_W-1:0];
  assign in_char  = s_axis_tdata[CMD_W +: CHAR_W];
  assign in_value = s_axis_tdata[CMD_W + CHAR_W +: VALUE_W];

  // Take a command only between commands
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  logic [COLOR_W-1:0] color_reg_q;
  logic [CHAR_W-1:0]  char_q;
  logic               hex_q;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [OP_W-1:0]      op_q, op_d;
  logic [PIXEL_X_W-1:0] px_q, px_d;
  logic [PIXEL_Y_W-1:0] py_q, py_d;
  logic [GLYPH_W-1:0]   glyph_q, glyph_d;
  logic [COLOR_W-1:0]   color_q, color_d;
  logic                 last_q, last_d;
  logic                 slot_free;
  logic                 load;

  logic [PIXEL_X_W-1:0] cur_px;
  logic [PIXEL_Y_W-1:0] cur_py;
  curs_cmd_t            curs_cmd;
  dig_ctrl_t            dig_ctrl;
  dig_sts_t             dig_sts;

  // The output register takes a new beat when empty or being drained
  assign slot_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    op_d    = OP_DRAW;
    px_d    = cur_px;
    py_d    = cur_py;
    glyph_d = char_q;
    color_d = color_reg_q;
    last_d  = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_CHAR:      state_d = (in_char == NEWLINE_CHAR) ? S_IDLE : S_GLYPH;
            CMD_BACKSPACE: state_d = S_ERASE;
            CMD_CLEAR:     state_d = S_CLEAR;
            CMD_DEC:       state_d = S_DIGITS;
            CMD_HEX:       state_d = S_DIGITS;
            default:       state_d = S_IDLE;
          endcase
        end
      end
      S_GLYPH: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ERASE: begin
        // Cursor has already stepped back; erase the cell now under it
        op_d    = OP_ERASE;
        glyph_d = '0;
        color_d = COLOR_BLACK;
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        op_d    = OP_CLEAR;
        px_d    = '0;
        py_d    = '0;
        glyph_d = '0;
        color_d = COLOR_BLACK;
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIGITS: begin
        glyph_d = digit_glyph(dig_sts.digit);
        last_d  = dig_sts.last;
        if (dig_sts.ready && slot_free) begin
          load = 1'b1;
          if (dig_sts.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Cursor moves: newline and backspace on the command beat, advance per glyph
  always_comb begin
    curs_cmd.newline   = in_accept && (in_cmd == CMD_CHAR) && (in_char == NEWLINE_CHAR);
    curs_cmd.backspace = in_accept && (in_cmd == CMD_BACKSPACE);
    curs_cmd.advance   = load && ((state_q == S_GLYPH) || (state_q == S_DIGITS));
    curs_cmd.home      = load && (state_q == S_CLEAR);
  end

  always_comb begin
    dig_ctrl.start = in_accept && ((in_cmd == CMD_DEC) || (in_cmd == CMD_HEX));
    dig_ctrl.hex   = (in_cmd == CMD_HEX);
    dig_ctrl.next  = load && (state_q == S_DIGITS);
  end

  // Sequencer state, valid flag and colour register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      color_reg_q <= COLOR_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        color_reg_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= in_char;
      hex_q  <= (in_cmd == CMD_HEX);
    end
    if (load) begin
      op_q    <= op_d;
      px_q    <= px_d;
      py_q    <= py_d;
      glyph_q <= glyph_d;
      color_q <= color_d;
      last_q  <= last_d;
    end
  end

  ccw_cursor u_cursor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (curs_cmd),
    .pixel_x_o (cur_px),
    .pixel_y_o (cur_py)
  );

  ccw_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (dig_ctrl),
    .value_i (in_value),
    .sts_o   (dig_sts)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {1'b0, color_q, glyph_q, py_q, px_q, op_q};

  // Digit unit only offers digits while the sequencer is printing a value
  `CCW_ASSERT(a_digits_owned, dig_sts.ready |-> (state_q == S_DIGITS), "digit unit ready outside value print")
  // A clear command leaves the input side closed on the next cycle
  `CCW_ASSERT(a_clear_blocks, (in_accept && in_cmd == CMD_CLEAR) |=> !s_axis_tready, "clear command did not hold the input")
  // Decimal printing only ever produces the ten ASCII digits
  `CCW_ASSERT_NEVER(a_dec_digit, load && state_q == S_DIGITS && !hex_q && (glyph_d > 8'h39 || glyph_d < ASCII_ZERO), "decimal digit out of range")

endmodule

// File: design/ccw_cursor.sv
// ----------------------------------------------------------------------------
// Console cursor
// Row and column registers with wrap, and the pixel origin of the cell.
// ----------------------------------------------------------------------------
module ccw_cursor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ccw_pkg::curs_cmd_t              cmd_i,
  output logic [ccw_pkg::PIXEL_X_W-1:0]   pixel_x_o,
  output logic [ccw_pkg::PIXEL_Y_W-1:0]   pixel_y_o
);
  import ccw_pkg::*;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [ROW_W-1:0] row_inc;

  assign row_inc = (row_q == ROW_MAX) ? '0 : row_q + 1'b1;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.home) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.newline) begin
      col_d = '0;
      row_d = row_inc;
    end else if (cmd_i.advance) begin
      if (col_q >= COL_MAX) begin
        col_d = '0;
        row_d = row_inc;
      end else begin
        col_d = col_q + 1'b1;
      end
    end else if (cmd_i.backspace) begin
      if (col_q == '0) begin
        col_d = COL_MAX;
        row_d = (row_q == '0) ? ROW_MAX : row_q - 1'b1;
      end else begin
        col_d = col_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Constant scaling, truncated to the coordinate widths
  assign pixel_x_o = PIXEL_X_W'(32'(col_q) * CELL_WIDTH);
  assign pixel_y_o = PIXEL_Y_W'(32'(row_q) * CELL_HEIGHT);

endmodule

// File: design/ccw_digits.sv
// ----------------------------------------------------------------------------
// Console digit unit
// Bit-serial binary to BCD conversion for decimal values, leading zero drop and digit shift-out.
// ----------------------------------------------------------------------------
module ccw_digits (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ccw_pkg::dig_ctrl_t             ctrl_i,
  input  logic [ccw_pkg::VALUE_W-1:0]    value_i,
  output ccw_pkg::dig_sts_t              sts_o
);
  import ccw_pkg::*;

  typedef enum logic [1:0] {
    D_IDLE,
    D_CONV,
    D_SKIP,
    D_OUT
  } phase_e;

  phase_e                phase_q;
  logic [VALUE_W-1:0]    bin_q;
  logic [DIGIT_BITS-1:0] digits_q;
  logic [DIGIT_BITS-1:0] adjusted;
  logic [CONV_CNT_W-1:0] conv_cnt_q;
  logic [DIG_CNT_W-1:0]  remain_q;
  logic [DIGIT_W-1:0]    top_digit;

  assign top_digit = digits_q[DIGIT_BITS-1 -: DIGIT_W];

  // Add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (digits_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adjusted[i*DIGIT_W +: DIGIT_W] = digits_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adjusted[i*DIGIT_W +: DIGIT_W] = digits_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= D_IDLE;
      remain_q   <= '0;
      conv_cnt_q <= '0;
    end else begin
      case (phase_q)
        D_IDLE: begin
          if (ctrl_i.start) begin
            remain_q   <= DIG_CNT_W'(DIGITS);
            conv_cnt_q <= CONV_CNT_W'(VALUE_W - 1);
            phase_q    <= ctrl_i.hex ? D_SKIP : D_CONV;
          end
        end
        D_CONV: begin
          if (conv_cnt_q == '0) begin
            phase_q <= D_SKIP;
          end else begin
            conv_cnt_q <= conv_cnt_q - 1'b1;
          end
        end
        D_SKIP: begin
          if (top_digit == '0 && remain_q > DIG_CNT_W'(1)) begin
            remain_q <= remain_q - 1'b1;
          end else begin
            phase_q <= D_OUT;
          end
        end
        D_OUT: begin
          if (ctrl_i.next) begin
            if (remain_q == DIG_CNT_W'(1)) begin
              phase_q <= D_IDLE;
            end else begin
              remain_q <= remain_q - 1'b1;
            end
          end
        end
        default: phase_q <= D_IDLE;
      endcase
    end
  end

  // Digit and binary shift registers, no reset
  always_ff @(posedge clk_i) begin
    case (phase_q)
      D_IDLE: begin
        if (ctrl_i.start) begin
          bin_q    <= value_i;
          digits_q <= ctrl_i.hex ? DIGIT_BITS'(value_i) : '0;
        end
      end
      D_CONV: begin
        digits_q <= {adjusted[DIGIT_BITS-2:0], bin_q[VALUE_W-1]};
        bin_q    <= {bin_q[VALUE_W-2:0], 1'b0};
      end
      D_SKIP: begin
        if (top_digit == '0 && remain_q > DIG_CNT_W'(1)) begin
          digits_q <= {digits_q[DIGIT_BITS-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
      end
      D_OUT: begin
        if (ctrl_i.next) begin
          digits_q <= {digits_q[DIGIT_BITS-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
      end
      default: begin
        bin_q <= bin_q;
      end
    endcase
  end

  assign sts_o.ready = (phase_q == D_OUT);
  assign sts_o.last  = (remain_q == DIG_CNT_W'(1));
  assign sts_o.digit = top_digit;

endmodule

// File: dv/text_console_cursor_writer_core_tb.sv
// ----------------------------------------------------------------------------
// Console cursor writer core testbench
// Sends console commands over s_axis and keeps its own cursor and colour
// model. Each command is turned into the draw, erase and clear beats it should
// cause, and every m_axis beat is checked field by field against them in order.
// Both stream sides idle at random, and the output side is also held off for
// long stretches so that the core fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_console_cursor_writer_core_tb;
  import ccw_pkg::*;

  localparam int LATENCY_CYCLES = 64;      // worst decimal command plus margin
  localparam int HOLD_CYCLES    = 400;     // long output hold-off
  localparam int CMD_UNUSED_FIRST = 5;
  localparam int CMD_UNUSED_LAST  = 7;

  typedef struct {
    op_e                  op;
    logic [PIXEL_X_W-1:0] pixel_x;
    logic [PIXEL_Y_W-1:0] pixel_y;
    logic [GLYPH_W-1:0]   glyph;
    logic [COLOR_W-1:0]   colour;
    logic                 last;
  } draw_op_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [23:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Console model state
  int unsigned          cur_row;
  int unsigned          cur_col;
  logic [COLOR_W-1:0]   draw_colour;
  draw_op_t             queued_draw_ops[$];

  int fail_count    = 0;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  text_console_cursor_writer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Console model
  // ---------------------------------------------------------------------------
  function automatic void push_op(op_e op, int unsigned col, int unsigned row,
                                  logic [GLYPH_W-1:0] glyph,
                                  logic [COLOR_W-1:0] colour, logic last);
    draw_op_t d;
    d.op      = op;
    d.pixel_x = PIXEL_X_W'(col * CELL_WIDTH);
    d.pixel_y = PIXEL_Y_W'(row * CELL_HEIGHT);
    d.glyph   = glyph;
    d.colour  = colour;
    d.last    = last;
    queued_draw_ops.push_back(d);
  endfunction

  function automatic void next_row();
    cur_row = (cur_row + 1 >= ROWS) ? 0 : cur_row + 1;
  endfunction

  // Draw at the cursor, then advance with wrap onto the next row
  function automatic void draw_at_cursor(logic [GLYPH_W-1:0] glyph, logic last);
    push_op(OP_DRAW, cur_col, cur_row, glyph, draw_colour, last);
    cur_col++;
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      next_row();
    end
  endfunction

  function automatic void apply_console_command(logic [CMD_W-1:0] cmd,
                                                logic [CHAR_W-1:0] ch,
                                                logic [VALUE_W-1:0] val);
    int unsigned        v;
    int unsigned        base;
    int                 n;
    logic [DIGIT_W-1:0] digits [DIGITS];
    logic [DIGIT_W-1:0] d;
    case (cmd)
      CMD_CHAR: begin
        if (ch == NEWLINE_CHAR) begin
          cur_col = 0;
          next_row();
        end else begin
          draw_at_cursor(ch, 1'b1);
        end
      end
      CMD_BACKSPACE: begin
        if (cur_col == 0) begin
          cur_col = COLUMNS - 1;
          cur_row = (cur_row == 0) ? ROWS - 1 : cur_row - 1;
        end else begin
          cur_col--;
        end
        push_op(OP_ERASE, cur_col, cur_row, '0, COLOR_BLACK, 1'b1);
      end
      CMD_CLEAR: begin
        push_op(OP_CLEAR, 0, 0, '0, COLOR_BLACK, 1'b1);
        cur_row = 0;
        cur_col = 0;
      end
      CMD_DEC, CMD_HEX: begin
        base = (cmd == CMD_HEX) ? 16 : 10;
        v    = val;
        n    = 0;
        if (v == 0) begin
          draw_at_cursor(ASCII_ZERO, 1'b1);
        end else begin
          // collect least significant first, emit most significant first
          while (v != 0) begin
            digits[n] = DIGIT_W'(v % base);
            v = v / base;
            n++;
          end
          while (n > 0) begin
            n--;
            d = digits[n];
            draw_at_cursor((d < 10) ? ASCII_ZERO + GLYPH_W'(d)
                                    : ASCII_UPPER_A + GLYPH_W'(d - 10), n == 0);
          end
        end
      end
      default: ;  // unused codes: no beat, no state change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls, long hold-offs on request, beat checks
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    draw_op_t exp_op;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (queued_draw_ops.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        exp_op = queued_draw_ops.pop_front();
        compare_field("op",      exp_op.op,      m_axis_tdata[1:0]);
        compare_field("pixel_x", exp_op.pixel_x, m_axis_tdata[12:2]);
        compare_field("pixel_y", exp_op.pixel_y, m_axis_tdata[22:13]);
        compare_field("glyph",   exp_op.glyph,   m_axis_tdata[30:23]);
        compare_field("color",   exp_op.colour,  m_axis_tdata[54:31]);
        compare_field("last",    exp_op.last,    m_axis_tlast);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                              logic [VALUE_W-1:0] val);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, val, ch, cmd};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    apply_console_command(cmd, ch, val);
  endtask

  // Drop valid and hold until every queued beat has come out
  task automatic drain_draw_ops();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (queued_draw_ops.size() != 0);
  endtask

  task automatic set_draw_colour(logic [COLOR_W-1:0] colour);
    drain_draw_ops();
    // a newline or unused code may still be in flight
    repeat (LATENCY_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= colour;
    @(posedge clk_i);
    draw_colour = colour;
    cfg_we_i   <= 1'b0;
  endtask

  task automatic send_random_command();
    int unsigned        pick;
    int unsigned        w;
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  ch;
    logic [VALUE_W-1:0] val;
    pick = $urandom_range(99);
    ch   = CHAR_W'($urandom);
    w    = $urandom_range(31);
    val  = VALUE_W'($urandom >> (32 - w));  // spread of magnitudes
    if (pick < 35) begin
      cmd = CMD_CHAR;
    end else if (pick < 42) begin
      cmd = CMD_CHAR;
      ch  = NEWLINE_CHAR;
    end else if (pick < 54) begin
      cmd = CMD_BACKSPACE;
    end else if (pick < 58) begin
      cmd = CMD_CLEAR;
    end else if (pick < 76) begin
      cmd = CMD_DEC;
    end else if (pick < 94) begin
      cmd = CMD_HEX;
    end else begin
      cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    end
    send_command(cmd, ch, val);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_character_writes();
    send_command(CMD_CHAR, 8'h00, '0);
    send_command(CMD_CHAR, 8'hFF, '1);
    send_command(CMD_CHAR, 8'h55, '0);
    send_command(CMD_CHAR, 8'hAA, '0);
    send_command(CMD_CHAR, ASCII_UPPER_A, '0);
    send_command(CMD_CHAR, NEWLINE_CHAR, '0);
    send_command(CMD_W'(CMD_UNUSED_FIRST), 8'hFF, '1);
    send_command(CMD_W'(CMD_UNUSED_FIRST + 1), 8'h0A, 31'h2AAA_AAAA);
    send_command(CMD_W'(CMD_UNUSED_LAST), 8'h00, '0);
  endtask

  // Backspace from home wraps to the last cell; wrap back by newline and draw
  task automatic test_cursor_wrap();
    send_command(CMD_CLEAR, 8'h41, 31'h1234);
    send_command(CMD_BACKSPACE, '0, '0);
    send_command(CMD_CHAR, NEWLINE_CHAR, '0);
    send_command(CMD_BACKSPACE, '0, '0);
    send_command(CMD_CHAR, 8'h7E, '0);
    send_command(CMD_CHAR, 8'h21, '0);
    send_command(CMD_BACKSPACE, '0, '0);
  endtask

  task automatic test_value_output();
    send_command(CMD_DEC, '0, '0);
    send_command(CMD_HEX, '0, '0);
    send_command(CMD_DEC, '0, '1);
    send_command(CMD_HEX, '0, '1);
    send_command(CMD_HEX, '0, 31'h0ABC_DEF9);
    send_command(CMD_DEC, '0, 31'd1_000_000_000);
    send_command(CMD_DEC, '0, 31'd9);
  endtask

  task automatic test_colour_extremes();
    set_draw_colour(24'h000000);
    send_command(CMD_CHAR, 8'h5A, '0);
    send_command(CMD_HEX, '0, 31'hF);
    set_draw_colour(24'hFF0000);
    send_command(CMD_DEC, '0, 31'd42);
    set_draw_colour(24'hFFFFFF);
    send_command(CMD_CHAR, 8'h30, '0);
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, int count,
                                     logic [COLOR_W-1:0] colour);
    set_draw_colour(colour);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_random_command();
  endtask

  // Hold the output off while commands keep coming, then pause the input
  task automatic test_output_backpressure();
    drain_draw_ops();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests++;
    repeat (16) send_command(CMD_DEC, CHAR_W'($urandom), VALUE_W'($urandom));
    drain_draw_ops();
    rx_idle_pct = 47;
    repeat (6) send_command(CMD_HEX, CHAR_W'($urandom), VALUE_W'($urandom));
    repeat (4) send_random_command();
  endtask

  initial begin
    cur_row     = 0;
    cur_col     = 0;
    draw_colour = COLOR_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 33;
    rx_idle_pct = 47;
    test_character_writes();
    test_cursor_wrap();
    test_value_output();
    test_colour_extremes();
    test_random_traffic(33, 47, 26, COLOR_W'($urandom));
    test_random_traffic(47, 33, 26, 24'h000000);
    test_random_traffic(0, 0, 25, 24'hFFFFFF);
    test_output_backpressure();

    drain_draw_ops();
    repeat (LATENCY_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: text_console_cursor_writer_core.f
+incdir+design
design/ccw_pkg.sv
design/ccw_cursor.sv
design/ccw_digits.sv
design/text_console_cursor_writer_core.sv
dv/text_console_cursor_writer_core_tb.sv
